### sv/mst_pkg.sv
`default_nettype none
package mst_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int ROUND_MS  = 100;
  localparam int REM_W     = $clog2(ROUND_MS + 1);
  localparam int TIME_BITS = 32;
  localparam int PER_W     = 24;
  localparam int PERIOD_W  = 25;
  localparam int TAG_W     = 16;
  localparam int ORDER_W   = 32;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_ARM  = 2'd1,
    FUNC_DEL  = 2'd2,
    FUNC_CHG  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_INVALID   = 2'd1,
    STAT_NO_FREE   = 2'd2,
    STAT_NOT_ARMED = 2'd3
  } status_e;

  typedef enum logic {
    KIND_FIRED = 1'b0,
    KIND_REPLY = 1'b1
  } kind_e;

  localparam logic [1:0] MODE_ONESHOT  = 2'd0;
  localparam logic [1:0] MODE_PERIODIC = 2'd1;

endpackage
`default_nettype wire

### sv/mst_round.sv
`default_nettype none
module mst_round (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mst_pkg::PER_W-1:0]    per_i,
  output logic                         done_o,
  output logic [mst_pkg::PERIOD_W-1:0] rnd_o
);
  import mst_pkg::*;

  localparam int RECIP_SHIFT = PERIOD_W + $clog2(ROUND_MS);
  localparam int PROD_W      = RECIP_SHIFT + PERIOD_W;
  localparam logic [PROD_W-1:0] RECIP =
    PROD_W'(((64'd1 << RECIP_SHIFT) + 64'(ROUND_MS - 1)) / 64'(ROUND_MS));

  logic                sum_vld_q;
  logic                quo_vld_q;
  logic                done_q;
  logic [PERIOD_W-1:0] sum_q;
  logic [PERIOD_W-1:0] quo_q;
  logic [PERIOD_W-1:0] rnd_q;

  assign done_o = done_q;
  assign rnd_o  = rnd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
      quo_vld_q <= 1'b0;
      done_q    <= 1'b0;
      sum_q     <= '0;
      quo_q     <= '0;
      rnd_q     <= '0;
    end else begin
      sum_vld_q <= start_i;
      quo_vld_q <= sum_vld_q;
      done_q    <= quo_vld_q;
      if (start_i) begin
        sum_q <= PERIOD_W'(per_i) + PERIOD_W'(ROUND_MS - 1);
      end
      if (sum_vld_q) begin
        quo_q <= PERIOD_W'((PROD_W'(sum_q) * RECIP) >> RECIP_SHIFT);
      end
      if (quo_vld_q) begin
        rnd_q <= quo_q * PERIOD_W'(ROUND_MS);
      end
    end
  end

endmodule
`default_nettype wire

### sv/multi_slot_software_timer_core.sv
// Multi-slot millisecond timer table.
// Input stream: tuser carries the function (tick, arm, delete, change period),
// tdata the slot, period, mode and tag. Output stream carries firing events
// and replies; tlast marks the final result of one input transfer.
// One input is taken at a time; tready is high only while the sequencer idles.
// Arm: the period is rounded up (add, multiply by the reciprocal of
// ROUND_MS, multiply back), then the table is searched for the lowest free
// slot, then the reply is sent. Change: the same rounding, then the reply.
// Delete and rejected commands go straight to the reply.
// Tick: each firing needs a full pass over the slot table, one slot per cycle
// through a single shared adder, so a tick with n due slots makes n passes
// (one pass if none is due), each ending in the firing of the most overdue
// due slot, ties going to the one armed or re-armed first.
// A result waits in the output register while tready is low; the sequencer
// holds its next result until that register drains, but a new input can be
// taken while the last result of the previous one still waits.
// Reset empties the table and clears the time base and the arm counter.
`default_nettype none
module multi_slot_software_timer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] slot, [27:4] period_ms, [29:28] timer_mode, [45:30] user_tag
  input  logic [47:0] s_axis_tdata,
  // [1:0] func
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] timer_slot, [19:4] tag_out, [21:20] status
  output logic [23:0] m_axis_tdata,
  // [0] event_kind
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);
  import mst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_FIND,
    S_SCAN,
    S_FIRE,
    S_REPLY
  } state_e;

  state_e state_q;

  logic                 valid_q    [SLOTS];
  logic                 periodic_q [SLOTS];
  logic [PERIOD_W-1:0]  period_q   [SLOTS];
  logic [TIME_BITS-1:0] deadline_q [SLOTS];
  logic [TAG_W-1:0]     tag_q      [SLOTS];
  logic [ORDER_W-1:0]   order_q    [SLOTS];

  logic [TIME_BITS-1:0] now_q;
  logic [ORDER_W-1:0]   order_cnt_q;

  func_e                func_q;
  logic [3:0]           slot_q;
  logic [1:0]           mode_q;
  logic [TAG_W-1:0]     utag_q;

  logic [SLOT_W-1:0]    scan_q;
  logic [SLOT_W-1:0]    best_q;
  logic                 best_vld_q;
  logic [TIME_BITS-1:0] best_age_q;
  logic [ORDER_W-1:0]   best_order_q;
  logic [CNT_W-1:0]     cnt_q;

  logic [3:0]           rep_slot_q;
  status_e              rep_status_q;

  logic                 out_vld_q;
  kind_e                out_kind_q;
  logic [3:0]           out_slot_q;
  logic [TAG_W-1:0]     out_tag_q;
  status_e              out_status_q;
  logic                 out_last_q;

  func_e                in_func;
  logic [3:0]           in_slot;
  logic [PER_W-1:0]     in_per;
  logic [1:0]           in_mode;
  logic [TAG_W-1:0]     in_tag;
  logic [SLOT_W-1:0]    in_idx;
  logic                 in_accept;
  logic                 in_slot_ok;
  logic                 arm_args_ok;
  logic                 chg_args_ok;
  logic                 rnd_start;
  logic                 rnd_done;
  logic [PERIOD_W-1:0]  rnd;

  logic [SLOT_W-1:0]    rd_idx;
  logic [TIME_BITS-1:0] alu_b;
  logic                 alu_cin;
  logic [TIME_BITS-1:0] alu_sum;
  logic                 due;
  logic                 better;
  logic [ORDER_W-1:0]   order_diff;
  logic [CNT_W-1:0]     cnt_nxt;
  logic                 scan_last;
  logic                 out_free;
  logic                 arm_we;
  logic                 chg_we;
  logic                 fire_go;

  assign in_func   = func_e'(s_axis_tuser);
  assign in_slot   = s_axis_tdata[3:0];
  assign in_per    = s_axis_tdata[27:4];
  assign in_mode   = s_axis_tdata[29:28];
  assign in_tag    = s_axis_tdata[45:30];
  assign in_idx    = SLOT_W'(in_slot);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    in_slot_ok  = (int'(in_slot) < SLOTS) && valid_q[in_idx];
    arm_args_ok = (in_per != '0) && (in_mode == MODE_ONESHOT || in_mode == MODE_PERIODIC);
    chg_args_ok = in_slot_ok && periodic_q[in_idx] && (in_per != '0);
    rnd_start   = in_accept && ((in_func == FUNC_ARM && arm_args_ok) ||
                                (in_func == FUNC_CHG && chg_args_ok));
  end

  mst_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rnd_start),
    .per_i   (in_per),
    .done_o  (rnd_done),
    .rnd_o   (rnd)
  );

  assign rd_idx = (state_q == S_FIRE) ? best_q : scan_q;

  always_comb begin
    unique case (state_q)
      S_SCAN: begin
        alu_b   = ~deadline_q[rd_idx];
        alu_cin = 1'b1;
      end
      S_FIND: begin
        alu_b   = TIME_BITS'(rnd);
        alu_cin = 1'b0;
      end
      S_FIRE: begin
        alu_b   = TIME_BITS'(period_q[rd_idx]);
        alu_cin = 1'b0;
      end
      default: begin
        alu_b   = '0;
        alu_cin = 1'b0;
      end
    endcase
    alu_sum = now_q + alu_b + TIME_BITS'(alu_cin);
  end

  always_comb begin
    due = valid_q[rd_idx] &&
          (!alu_sum[TIME_BITS-1] || (alu_sum[TIME_BITS-2:0] == '0));
    order_diff = order_q[rd_idx] - best_order_q;
    better = !best_vld_q || (alu_sum > best_age_q) ||
             ((alu_sum == best_age_q) && order_diff[ORDER_W-1]);
    cnt_nxt   = due ? cnt_q + 1'b1 : cnt_q;
    scan_last = (scan_q == SLOT_W'(SLOTS - 1));
    out_free  = !out_vld_q || m_axis_tready;
    arm_we    = (state_q == S_FIND) && !valid_q[scan_q];
    chg_we    = (state_q == S_ROUND) && rnd_done && (func_q == FUNC_CHG);
    fire_go   = (state_q == S_FIRE) && out_free;
  end

  always_ff @(posedge clk_i) begin
    if (arm_we) begin
      period_q[scan_q]   <= rnd;
      deadline_q[scan_q] <= alu_sum;
      tag_q[scan_q]      <= utag_q;
      order_q[scan_q]    <= order_cnt_q;
    end
    if (chg_we) begin
      period_q[SLOT_W'(slot_q)] <= rnd;
    end
    if (fire_go && periodic_q[best_q]) begin
      deadline_q[best_q] <= alu_sum;
      order_q[best_q]    <= order_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      for (int i = 0; i < SLOTS; i++) begin
        valid_q[i]    <= 1'b0;
        periodic_q[i] <= 1'b0;
      end
      now_q        <= '0;
      order_cnt_q  <= '0;
      func_q       <= FUNC_TICK;
      slot_q       <= '0;
      mode_q       <= '0;
      utag_q       <= '0;
      scan_q       <= '0;
      best_q       <= '0;
      best_vld_q   <= 1'b0;
      best_age_q   <= '0;
      best_order_q <= '0;
      cnt_q        <= '0;
      rep_slot_q   <= '0;
      rep_status_q <= STAT_OK;
      out_vld_q    <= 1'b0;
      out_kind_q   <= KIND_REPLY;
      out_slot_q   <= '0;
      out_tag_q    <= '0;
      out_status_q <= STAT_OK;
      out_last_q   <= 1'b0;
    end else begin
      if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            func_q <= in_func;
            slot_q <= in_slot;
            mode_q <= in_mode;
            utag_q <= in_tag;
            unique case (in_func)
              FUNC_TICK: begin
                now_q      <= now_q + 1'b1;
                scan_q     <= '0;
                cnt_q      <= '0;
                best_vld_q <= 1'b0;
                state_q    <= S_SCAN;
              end
              FUNC_ARM: begin
                if (arm_args_ok) begin
                  state_q <= S_ROUND;
                end else begin
                  rep_slot_q   <= '0;
                  rep_status_q <= STAT_INVALID;
                  state_q      <= S_REPLY;
                end
              end
              FUNC_DEL: begin
                rep_slot_q <= in_slot;
                state_q    <= S_REPLY;
                if (!in_slot_ok) begin
                  rep_status_q <= STAT_NOT_ARMED;
                end else begin
                  valid_q[in_idx]    <= 1'b0;
                  periodic_q[in_idx] <= 1'b0;
                  rep_status_q       <= STAT_OK;
                end
              end
              FUNC_CHG: begin
                rep_slot_q <= in_slot;
                if (!in_slot_ok) begin
                  rep_status_q <= STAT_NOT_ARMED;
                  state_q      <= S_REPLY;
                end else if (!chg_args_ok) begin
                  rep_status_q <= STAT_INVALID;
                  state_q      <= S_REPLY;
                end else begin
                  state_q <= S_ROUND;
                end
              end
            endcase
          end
        end
        S_ROUND: begin
          if (rnd_done) begin
            if (func_q == FUNC_ARM) begin
              scan_q  <= '0;
              state_q <= S_FIND;
            end else begin
              rep_status_q <= STAT_OK;
              state_q      <= S_REPLY;
            end
          end
        end
        S_FIND: begin
          if (!valid_q[scan_q]) begin
            valid_q[scan_q]    <= 1'b1;
            periodic_q[scan_q] <= (mode_q == MODE_PERIODIC);
            order_cnt_q        <= order_cnt_q + 1'b1;
            rep_slot_q         <= 4'(scan_q);
            rep_status_q       <= STAT_OK;
            state_q            <= S_REPLY;
          end else if (scan_last) begin
            rep_slot_q   <= '0;
            rep_status_q <= STAT_NO_FREE;
            state_q      <= S_REPLY;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_SCAN: begin
          cnt_q <= cnt_nxt;
          if (due && better) begin
            best_q       <= scan_q;
            best_vld_q   <= 1'b1;
            best_age_q   <= alu_sum;
            best_order_q <= order_q[rd_idx];
          end
          if (scan_last) begin
            state_q <= (cnt_nxt != '0) ? S_FIRE : S_IDLE;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_FIRE: begin
          if (out_free) begin
            out_vld_q    <= 1'b1;
            out_kind_q   <= KIND_FIRED;
            out_slot_q   <= 4'(best_q);
            out_tag_q    <= tag_q[rd_idx];
            out_status_q <= STAT_OK;
            out_last_q   <= (cnt_q == CNT_W'(1));
            if (periodic_q[best_q]) begin
              order_cnt_q <= order_cnt_q + 1'b1;
            end else begin
              valid_q[best_q] <= 1'b0;
            end
            if (cnt_q == CNT_W'(1)) begin
              state_q <= S_IDLE;
            end else begin
              scan_q     <= '0;
              cnt_q      <= '0;
              best_vld_q <= 1'b0;
              state_q    <= S_SCAN;
            end
          end
        end
        S_REPLY: begin
          if (out_free) begin
            out_vld_q    <= 1'b1;
            out_kind_q   <= KIND_REPLY;
            out_slot_q   <= rep_slot_q;
            out_tag_q    <= '0;
            out_status_q <= rep_status_q;
            out_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_status_q, out_tag_q, out_slot_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

### test/mst_event_checker.sv
module mst_event_checker
  import mst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [47:0] in_data_i,
  input  logic [1:0]  in_func_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [23:0] out_data_i,
  input  logic        out_kind_i,
  input  logic        out_last_i,
  output int          errors_o,
  output int          pending_o,
  output int          fired_o,
  output int          replies_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
    status_e           status;
    logic              last;
  } timer_event_t;

  timer_event_t expected_events_q[$];

  logic [SLOTS-1:0]     armed;
  logic [SLOTS-1:0]     repeats;
  logic [PERIOD_W-1:0]  interval_ms [SLOTS];
  logic [TIME_BITS-1:0] due_ms      [SLOTS];
  logic [TAG_W-1:0]     tag_of      [SLOTS];
  logic [ORDER_W-1:0]   seq_of      [SLOTS];
  logic [TIME_BITS-1:0] clock_ms;
  logic [ORDER_W-1:0]   next_seq;
  int                   mismatches;
  int                   fired_seen;
  int                   replies_seen;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("[%0t] MISMATCH %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [PERIOD_W-1:0] rounded_ms(input logic [PER_W-1:0] req);
    logic [31:0] up;
    up = ((32'(req) + 32'(ROUND_MS - 1)) / 32'(ROUND_MS)) * 32'(ROUND_MS);
    return up[PERIOD_W-1:0];
  endfunction

  function automatic logic deadline_reached(input logic [TIME_BITS-1:0] deadline);
    logic [TIME_BITS-1:0] ahead;
    ahead = deadline - clock_ms;
    return (ahead == '0) || ahead[TIME_BITS-1];
  endfunction

  function automatic logic fires_first(input int a, input int b);
    logic [TIME_BITS-1:0] age_a;
    logic [TIME_BITS-1:0] age_b;
    logic [ORDER_W-1:0]   seq_gap;
    age_a = clock_ms - due_ms[a];
    age_b = clock_ms - due_ms[b];
    if (age_a != age_b) return age_a > age_b;
    seq_gap = seq_of[a] - seq_of[b];
    return seq_gap[ORDER_W-1];
  endfunction

  task automatic push_event(input kind_e kind, input logic [SLOT_W-1:0] slot,
                            input logic [TAG_W-1:0] tag, input status_e status,
                            input logic last);
    timer_event_t ev;
    ev.kind   = kind;
    ev.slot   = slot;
    ev.tag    = tag;
    ev.status = status;
    ev.last   = last;
    expected_events_q.push_back(ev);
  endtask

  task automatic predict_tick();
    logic [SLOTS-1:0] to_fire;
    int n;
    int k;
    int i;
    int pick;
    clock_ms = clock_ms + 1'b1;
    n = 0;
    for (i = 0; i < SLOTS; i++) begin
      to_fire[i] = armed[i] && deadline_reached(due_ms[i]);
      if (to_fire[i]) n++;
    end
    for (k = 0; k < n; k++) begin
      pick = -1;
      for (i = 0; i < SLOTS; i++) begin
        if (to_fire[i] && (pick < 0 || fires_first(i, pick))) pick = i;
      end
      to_fire[pick] = 1'b0;
      push_event(KIND_FIRED, SLOT_W'(pick), tag_of[pick], STAT_OK, k == n - 1);
      if (repeats[pick]) begin
        due_ms[pick] = clock_ms + TIME_BITS'(interval_ms[pick]);
        seq_of[pick] = next_seq;
        next_seq     = next_seq + 1'b1;
      end else begin
        armed[pick] = 1'b0;
      end
    end
  endtask

  task automatic predict_command(input func_e func, input logic [47:0] data);
    logic [SLOT_W-1:0] slot;
    logic [PER_W-1:0]  req_ms;
    logic [1:0]        mode;
    logic [TAG_W-1:0]  tag;
    int                free_slot;
    int                i;
    slot   = data[3:0];
    req_ms = data[27:4];
    mode   = data[29:28];
    tag    = data[45:30];
    case (func)
      FUNC_ARM: begin
        free_slot = -1;
        for (i = SLOTS - 1; i >= 0; i--) begin
          if (!armed[i]) free_slot = i;
        end
        if (req_ms == '0 || mode > MODE_PERIODIC) begin
          push_event(KIND_REPLY, '0, '0, STAT_INVALID, 1'b1);
        end else if (free_slot < 0) begin
          push_event(KIND_REPLY, '0, '0, STAT_NO_FREE, 1'b1);
        end else begin
          armed[free_slot]       = 1'b1;
          repeats[free_slot]     = (mode == MODE_PERIODIC);
          interval_ms[free_slot] = rounded_ms(req_ms);
          due_ms[free_slot]      = clock_ms + TIME_BITS'(rounded_ms(req_ms));
          tag_of[free_slot]      = tag;
          seq_of[free_slot]      = next_seq;
          next_seq               = next_seq + 1'b1;
          push_event(KIND_REPLY, SLOT_W'(free_slot), '0, STAT_OK, 1'b1);
        end
      end
      FUNC_DEL: begin
        if (!armed[slot]) begin
          push_event(KIND_REPLY, slot, '0, STAT_NOT_ARMED, 1'b1);
        end else begin
          armed[slot]   = 1'b0;
          repeats[slot] = 1'b0;
          push_event(KIND_REPLY, slot, '0, STAT_OK, 1'b1);
        end
      end
      FUNC_CHG: begin
        if (!armed[slot]) begin
          push_event(KIND_REPLY, slot, '0, STAT_NOT_ARMED, 1'b1);
        end else if (!repeats[slot] || req_ms == '0) begin
          push_event(KIND_REPLY, slot, '0, STAT_INVALID, 1'b1);
        end else begin
          interval_ms[slot] = rounded_ms(req_ms);
          push_event(KIND_REPLY, slot, '0, STAT_OK, 1'b1);
        end
      end
      default: begin
        predict_tick();
      end
    endcase
  endtask

  task automatic check_event();
    timer_event_t want;
    if (expected_events_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result: kind %0d slot %0d status %0d",
                                out_kind_i, out_data_i[3:0], out_data_i[21:20]));
    end else begin
      want = expected_events_q.pop_front();
      if (out_kind_i !== want.kind)
        report_mismatch($sformatf("event_kind got %0d, expected %0d", out_kind_i, want.kind));
      if (out_data_i[3:0] !== want.slot)
        report_mismatch($sformatf("timer_slot got %0d, expected %0d",
                                  out_data_i[3:0], want.slot));
      if (out_data_i[19:4] !== want.tag)
        report_mismatch($sformatf("tag_out got %h, expected %h", out_data_i[19:4], want.tag));
      if (out_data_i[21:20] !== want.status)
        report_mismatch($sformatf("status got %0d, expected %0d",
                                  out_data_i[21:20], want.status));
      if (out_last_i !== want.last)
        report_mismatch($sformatf("tlast got %0d, expected %0d", out_last_i, want.last));
      if (want.kind == KIND_FIRED) fired_seen++;
      else replies_seen++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_events_q.delete();
      armed        = '0;
      repeats      = '0;
      clock_ms     = '0;
      next_seq     = '0;
      mismatches   = 0;
      fired_seen   = 0;
      replies_seen = 0;
      errors_o    <= 0;
      pending_o   <= 0;
      fired_o     <= 0;
      replies_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_event();
      if (in_valid_i && in_ready_i) predict_command(func_e'(in_func_i), in_data_i);
      errors_o  <= mismatches;
      pending_o <= expected_events_q.size();
      fired_o   <= fired_seen;
      replies_o <= replies_seen;
    end
  end

endmodule

### test/tb_multi_slot_software_timer_core.sv
module tb_multi_slot_software_timer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mst_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [1:0] MODE_UNUSED_LO = 2'd2;
  localparam logic [1:0] MODE_UNUSED_HI = 2'd3;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent          = 0;
  int ticks_sent    = 0;
  int stall_cycles  = 0;
  int errors;
  int pending;
  int fired;
  int replies;

  multi_slot_software_timer_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  mst_event_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_func_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_kind_i  (m_axis_tuser),
    .out_last_i  (m_axis_tlast),
    .errors_o    (errors),
    .pending_o   (pending),
    .fired_o     (fired),
    .replies_o   (replies)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               stall_cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_command(input func_e func, input logic [3:0] slot,
                              input logic [23:0] period_ms, input logic [1:0] mode,
                              input logic [15:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {2'b00, tag, mode, period_ms, slot};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    if (func == FUNC_TICK) ticks_sent++;
  endtask

  function automatic logic [23:0] rand_period();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 24'($urandom_range(1, 100));
    if (r < 85) return 24'($urandom_range(101, 300));
    if (r < 95) return 24'($urandom);
    return (r < 97) ? 24'd0 : 24'hFFFFFF;
  endfunction

  task automatic issue_tick();
    send_command(FUNC_TICK, 4'($urandom), 24'($urandom), 2'($urandom), 16'($urandom));
  endtask

  task automatic arm_random();
    logic [1:0] mode;
    mode = ($urandom_range(99) < 8) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(1));
    send_command(FUNC_ARM, 4'($urandom), rand_period(), mode, 16'($urandom));
  endtask

  task automatic poke_slot();
    func_e func;
    func = ($urandom_range(99) < 60) ? FUNC_CHG : FUNC_DEL;
    send_command(func, 4'($urandom), rand_period(), 2'($urandom), 16'($urandom));
  endtask

  task automatic clear_table();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      send_command(FUNC_DEL, 4'(i), 24'($urandom), 2'($urandom), 16'($urandom));
    end
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic run_scenario(input int limit);
    int pick;
    int i;
    int count;
    pick = $urandom_range(99);
    if (pick < 55) begin
      count = $urandom_range(1, SLOTS + 1);
      for (i = 0; i < count && sent < limit; i++) begin
        arm_random();
        if ($urandom_range(99) < 20 && sent < limit) poke_slot();
      end
      repeat ($urandom_range(100, 320)) if (sent < limit) issue_tick();
    end else if (pick < 75) begin
      repeat ($urandom_range(2, 8)) if (sent < limit) poke_slot();
      repeat ($urandom_range(1, 120)) if (sent < limit) issue_tick();
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 10)) begin
        if (sent < limit) begin
          send_command(func_e'(2'($urandom_range(3))), 4'($urandom), rand_period(),
                       2'($urandom), 16'($urandom));
        end
      end
    end else begin
      clear_table();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct <= 26;
    recv_idle_pct <= 65;

    send_command(FUNC_TICK, 4'hF, 24'hFFFFFF, MODE_UNUSED_HI, 16'hFFFF);
    send_command(FUNC_ARM, 4'h0, 24'd0, MODE_ONESHOT, 16'h1234);
    send_command(FUNC_ARM, 4'h0, 24'd1, MODE_UNUSED_LO, 16'h1234);
    send_command(FUNC_ARM, 4'h0, 24'd100, MODE_UNUSED_HI, 16'h1234);
    send_command(FUNC_ARM, 4'hF, 24'd1, MODE_ONESHOT, 16'hFFFF);
    send_command(FUNC_ARM, 4'h0, 24'hFFFFFF, MODE_PERIODIC, 16'h0000);
    send_command(FUNC_ARM, 4'h0, 24'd100, MODE_PERIODIC, 16'hA5A5);
    send_command(FUNC_ARM, 4'h0, 24'd101, MODE_PERIODIC, 16'h5A5A);
    send_command(FUNC_DEL, 4'hF, 24'd0, MODE_ONESHOT, 16'h0000);
    send_command(FUNC_CHG, 4'hE, 24'd50, MODE_ONESHOT, 16'h0000);
    send_command(FUNC_CHG, 4'h0, 24'd50, MODE_ONESHOT, 16'h0000);
    send_command(FUNC_CHG, 4'h1, 24'd0, MODE_ONESHOT, 16'h0000);
    send_command(FUNC_CHG, 4'h1, 24'hFFFFFF, MODE_ONESHOT, 16'h0000);
    send_command(FUNC_CHG, 4'h2, 24'd99, MODE_ONESHOT, 16'h0000);
    send_command(FUNC_DEL, 4'h3, 24'd0, MODE_ONESHOT, 16'h0000);
    send_command(FUNC_DEL, 4'h3, 24'd0, MODE_ONESHOT, 16'h0000);
    send_command(FUNC_ARM, 4'h9, 24'd200, MODE_ONESHOT, 16'hC3C3);

    // fill every slot at one deadline, overflow the table, then fire them all on one tick
    clear_table();
    repeat (SLOTS + 1) begin
      send_command(FUNC_ARM, 4'($urandom), 24'($urandom_range(1, 100)), 2'($urandom_range(1)),
                   16'($urandom));
    end
    repeat (100) issue_tick();

    while (sent < 170) run_scenario(170);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    send_idle_pct <= 65;
    recv_idle_pct <= 26;

    while (sent < 340) run_scenario(340);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    send_idle_pct <= 0;
    recv_idle_pct <= 0;

    while (sent < 500) run_scenario(500);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d commands, %0d of them 1 ms ticks, under three idle mixes.",
             sent, ticks_sent);
    $display("Checked %0d timer firings and %0d command replies; %0d mismatches.",
             fired, replies, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### multi_slot_software_timer_core.f
sv/mst_pkg.sv
sv/mst_round.sv
sv/multi_slot_software_timer_core.sv
test/mst_event_checker.sv
test/tb_multi_slot_software_timer_core.sv
